>>> hdl/utf16_to_utf8_transcoder_macros.svh
// Assertion macros for the UTF-16 to UTF-8 transcoder.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define U2U_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define U2U_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

>>> hdl/u2u_pkg.sv
// Package: types, constants and encode functions for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u2u_pkg;

  localparam int CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_COLON_FIX = 3'd0;

  localparam logic [15:0] FULLWIDTH_COLON = 16'hFF1A;
  localparam logic [15:0] ASCII_COLON     = 16'h003A;
  localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  cnt;
  } enc_t;

  typedef struct packed {
    logic [47:0] bytes;
    logic [2:0]  cnt;
    logic        str_end;
  } batch_t;

  function automatic enc_t enc16(input logic [15:0] cp);
    enc_t r;
    r.bytes = '0;
    if (cp < 16'h0080) begin
      r.bytes[7:0] = cp[7:0];
      r.cnt        = 3'd1;
    end else if (cp < 16'h0800) begin
      r.bytes[7:0]  = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[15:8] = 8'h80 | {2'b00, cp[5:0]};
      r.cnt         = 3'd2;
    end else begin
      r.bytes[7:0]   = 8'hE0 | {4'b0000, cp[15:12]};
      r.bytes[15:8]  = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[23:16] = 8'h80 | {2'b00, cp[5:0]};
      r.cnt          = 3'd3;
    end
    return r;
  endfunction

  function automatic enc_t enc_pair(input logic [9:0] hi, input logic [9:0] lo);
    enc_t        r;
    logic [20:0] cp;
    cp = SUPP_BASE + {1'b0, hi, lo};
    r.bytes[7:0]   = 8'hF0 | {5'b00000, cp[20:18]};
    r.bytes[15:8]  = 8'h80 | {2'b00, cp[17:12]};
    r.bytes[23:16] = 8'h80 | {2'b00, cp[11:6]};
    r.bytes[31:24] = 8'h80 | {2'b00, cp[5:0]};
    r.cnt          = 3'd4;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level.
// Throughput: one input item per cycle at best; one output byte per cycle while
// out_stall is low; a multi-byte item stalls the input until its last byte is taken.
// Reset (synchronous, rst_n low): pipeline empty, no surrogate held, colon fix enabled.
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"
module utf16_to_utf8_transcoder
  import u2u_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [15:0]         in_code_unit,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     out_string_end,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic        s1_vld_r;
  logic [15:0] s1_unit_r;
  logic        colon_en_r;
  logic        load_rdy, advance, in_xfer;
  batch_t      batch;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_COLON_FIX) ? {31'h0, colon_en_r} : 32'h0;
  assign in_stall = s1_vld_r && !load_rdy;
  assign in_xfer  = in_valid && !in_stall;
  assign advance  = s1_vld_r && load_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_en_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == REG_COLON_FIX) begin
      colon_en_r <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_unit_r <= in_code_unit;
    end
  end

  u2u_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .unit     (s1_unit_r),
    .colon_en (colon_en_r),
    .batch    (batch)
  );

  u2u_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance),
    .batch          (batch),
    .load_rdy       (load_rdy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_string_end (out_string_end)
  );

  `U2U_ASSERT_NOW(a_end_is_last_zero, out_valid && out_string_end, out_last && out_byte == 8'h00)
  `U2U_ASSERT_NEXT(a_in_xfer_fills_s1, in_xfer, s1_vld_r)
  `U2U_ASSERT_NEXT(a_s1_held_on_stall, s1_vld_r && !load_rdy, s1_vld_r && $stable(s1_unit_r))

endmodule
`default_nettype wire

>>> hdl/u2u_encode.sv
// Encoder: surrogate hold state and expansion of one code unit into a byte batch.
`default_nettype none
module u2u_encode
  import u2u_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire logic [15:0] unit,
  input  wire logic        colon_en,
  output batch_t           batch
);

  logic       held_vld_r, held_vld_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic [15:0] u_fix;
  logic        is_low, is_high, prefix;
  enc_t        main_enc, held_enc;

  always_comb begin
    u_fix = (colon_en && unit == FULLWIDTH_COLON) ? ASCII_COLON : unit;
    is_low  = (u_fix[15:10] == LOW_SURR_TAG);
    is_high = (u_fix[15:10] == HIGH_SURR_TAG);
    held_enc = enc16({HIGH_SURR_TAG, held_bits_r});
    held_vld_nxt  = 1'b0;
    held_bits_nxt = held_bits_r;
    prefix        = held_vld_r;
    batch.str_end = 1'b0;
    main_enc      = '0;
    if (unit == 16'h0000) begin
      main_enc.cnt  = 3'd1;
      batch.str_end = 1'b1;
    end else if (held_vld_r && is_low) begin
      main_enc = enc_pair(held_bits_r, u_fix[9:0]);
      prefix   = 1'b0;
    end else if (is_high) begin
      held_vld_nxt  = 1'b1;
      held_bits_nxt = u_fix[9:0];
    end else begin
      main_enc = enc16(u_fix);
    end
    if (prefix) begin
      batch.bytes = {main_enc.bytes[23:0], held_enc.bytes[23:0]};
      batch.cnt   = 3'd3 + main_enc.cnt;
    end else begin
      batch.bytes = {16'h0000, main_enc.bytes};
      batch.cnt   = main_enc.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r  <= 1'b0;
      held_bits_r <= '0;
    end else if (advance) begin
      held_vld_r  <= held_vld_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/u2u_serializer.sv
// Result register: holds a byte batch and shifts it out one byte per transfer.
`default_nettype none
module u2u_serializer
  import u2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire batch_t     batch,
  output logic            load_rdy,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_string_end
);

  logic [47:0] bytes_r;
  logic [2:0]  cnt_r;
  logic        end_r;
  logic        take;

  assign out_valid      = (cnt_r != 3'd0);
  assign take           = out_valid && !out_stall;
  assign load_rdy       = (cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall);
  assign out_byte       = bytes_r[7:0];
  assign out_last       = (cnt_r == 3'd1);
  assign out_string_end = end_r && (cnt_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= batch.bytes;
      end_r   <= batch.str_end;
    end else if (take) begin
      bytes_r <= {8'h00, bytes_r[47:8]};
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the UTF-16 to UTF-8 transcoder: directed and random code units checked byte by byte.
`timescale 1ns / 100ps
module testbench;
  import u2u_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       str_end;
  } utf8_octet_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [15:0]         in_code_unit = 16'h0000;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                out_last;
  logic                out_string_end;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  utf8_octet_t expected_octets[$];
  logic        colon_fix_model = 1'b1;
  logic        surr_held = 1'b0;
  logic [9:0]  surr_high_bits = '0;

  logic        gaps_on = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned units_sent = 0;
  int unsigned octets_checked = 0;
  int unsigned fail_count = 0;

  utf16_to_utf8_transcoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_code_unit(in_code_unit),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_last(out_last), .out_string_end(out_string_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_octet(input logic [7:0] value);
    expected_octets.push_back('{octet: value, last: 1'b0, str_end: 1'b0});
  endfunction

  function automatic void encode_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_octet(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_octet(8'hC0 | {3'b000, cp[10:6]});
      add_octet(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_octet(8'hE0 | {4'b0000, cp[15:12]});
      add_octet(8'h80 | {2'b00, cp[11:6]});
      add_octet(8'h80 | {2'b00, cp[5:0]});
    end else begin
      add_octet(8'hF0 | {5'b00000, cp[20:18]});
      add_octet(8'h80 | {2'b00, cp[17:12]});
      add_octet(8'h80 | {2'b00, cp[11:6]});
      add_octet(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void transcode_unit(input logic [15:0] unit);
    logic [15:0] cu;
    logic [20:0] held_point;
    int unsigned start_count;
    utf8_octet_t tail;
    cu = unit;
    held_point = {5'b00000, HIGH_SURR_TAG, surr_high_bits};
    start_count = expected_octets.size();
    if (cu == 16'h0000) begin
      if (surr_held) encode_point(held_point);
      surr_held = 1'b0;
      expected_octets.push_back('{octet: 8'h00, last: 1'b1, str_end: 1'b1});
      return;
    end
    if (colon_fix_model && cu == FULLWIDTH_COLON) cu = ASCII_COLON;
    if (surr_held && cu[15:10] == LOW_SURR_TAG) begin
      surr_held = 1'b0;
      encode_point(SUPP_BASE + {1'b0, surr_high_bits, cu[9:0]});
    end else begin
      if (surr_held) begin
        encode_point(held_point);
        surr_held = 1'b0;
      end
      if (cu[15:10] == HIGH_SURR_TAG) begin
        surr_held = 1'b1;
        surr_high_bits = cu[9:0];
      end else begin
        encode_point({5'b00000, cu});
      end
    end
    if (expected_octets.size() > start_count) begin
      tail = expected_octets.pop_back();
      tail.last = 1'b1;
      expected_octets.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : result_check
    utf8_octet_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_octets.size() == 0) begin
        $error("unexpected output byte %02h", out_byte);
        fail_count++;
      end else begin
        want = expected_octets.pop_front();
        octets_checked++;
        if (out_byte !== want.octet) begin
          $error("out_byte: expected %02h, got %02h", want.octet, out_byte);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
        if (out_string_end !== want.str_end) begin
          $error("out_string_end: expected %0b, got %0b", want.str_end, out_string_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (gaps_on) begin
      out_stall <= ($urandom_range(99) < 33);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_unit(input logic [15:0] unit);
    if (gaps_on) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_code_unit <= unit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transcode_unit(unit);
    units_sent++;
  endtask

  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_octets.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_octets.size() > 0) begin
      $error("%0d expected bytes never arrived", expected_octets.size());
      fail_count++;
      expected_octets.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_colon_fix(input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_COLON_FIX;
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    colon_fix_model = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== value) begin
      $error("prdata colon_fix_enable: expected %0b, got %0b", value, prdata[0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_text(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_unit(16'($urandom_range(16'h007F, 16'h0001)));
      end else if (pick < 45) begin
        send_unit(16'($urandom_range(16'h07FF, 16'h0080)));
      end else if (pick < 65) begin
        if ($urandom_range(1)) send_unit(16'($urandom_range(16'hD7FF, 16'h0800)));
        else send_unit(16'($urandom_range(16'hFFFF, 16'hE000)));
      end else if (pick < 72) begin
        send_unit(FULLWIDTH_COLON);
      end else if (pick < 85) begin
        send_unit({HIGH_SURR_TAG, 10'($urandom_range(1023))});
        send_unit({LOW_SURR_TAG, 10'($urandom_range(1023))});
        sent++;
      end else if (pick < 90) begin
        send_unit(16'h0000);
      end else if (pick < 94) begin
        send_unit({HIGH_SURR_TAG, 10'($urandom_range(1023))});
      end else if (pick < 97) begin
        send_unit({LOW_SURR_TAG, 10'($urandom_range(1023))});
      end else begin
        send_unit(16'($urandom_range(16'hFFFF)));
      end
      sent++;
    end
    send_unit(16'h0000);
  endtask

  task automatic test_encoding_ranges();
    send_unit(16'h0001);
    send_unit(16'h007F);
    send_unit(16'h0080);
    send_unit(16'h07FF);
    send_unit(16'h0800);
    send_unit(16'hFFFF);
    send_unit(FULLWIDTH_COLON);
    send_unit(16'h0000);
    wait_for_results();
  endtask

  task automatic test_surrogates();
    send_unit(16'hD800);
    send_unit(16'hDC00);
    send_unit(16'hDBFF);
    send_unit(16'hDFFF);
    send_unit(16'hDC00);
    send_unit(16'hD800);
    send_unit(16'hDBFF);
    send_unit(16'hDC01);
    send_unit(16'hDA55);
    send_unit(16'h0041);
    send_unit(16'hD9AB);
    send_unit(FULLWIDTH_COLON);
    send_unit(16'hDB00);
    send_unit(16'h0000);
    wait_for_results();
  endtask

  task automatic test_colon_fix_off();
    write_colon_fix(1'b0);
    send_unit(FULLWIDTH_COLON);
    send_unit(16'hD812);
    send_unit(FULLWIDTH_COLON);
    send_unit(16'h0000);
    wait_for_results();
  endtask

  task automatic test_random_idle();
    gaps_on = 1'b1;
    send_random_text(150);
    wait_for_results();
  endtask

  task automatic test_random_streaming();
    gaps_on = 1'b0;
    send_random_text(100);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_cycles = 200;
    send_random_text(40);
    wait_for_results();
  endtask

  task automatic test_random_with_pause();
    gaps_on = 1'b1;
    send_random_text(65);
    wait_for_results();
    send_random_text(65);
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encoding_ranges();
    test_surrogates();
    test_colon_fix_off();
    test_random_streaming();
    test_backpressure();
    write_colon_fix(1'b1);
    test_random_idle();
    test_random_with_pause();
    $display("Sent %0d code units and checked %0d UTF-8 bytes", units_sent, octets_checked);
    $display("Covered 1-4 byte forms, lone and paired surrogates, colon fix on and off");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
